@@ src/pgd_pkg.sv @@
// ---------------------------------------------------------------------------
// pgd_pkg: shared definitions for the polar Gaussian deviate pair core
// Constants, the queue entry type and the default output format.
// ---------------------------------------------------------------------------
`default_nettype none

package pgd_pkg;

  // Default number of fraction bits in each output deviate.
  localparam int OUT_FRAC_BITS_DEF = 26;

  // Depth of the queue between the front and the back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // ln 2 rounded to 56 fraction bits.
  localparam logic [63:0] LN2_Q56 = 64'h00B1_7217_F7D1_CF7A;

  // Offset that centers a 31-bit uniform word around zero.
  localparam logic [31:0] HALF_RANGE = 32'h7FFF_FFFF;

  // Upper bound (exclusive) on the series index of the logarithm.
  localparam logic [7:0] SERIES_K_LIMIT = 8'd200;

  // One pair that lies strictly inside the unit circle.
  typedef struct packed {
    logic [61:0] sq_a;   // a^2
    logic [61:0] sq_b;   // b^2
    logic [61:0] s_int;  // a^2 + b^2, below 2^62
    logic        neg_a;
    logic        neg_b;
  } pgd_entry_t;

endpackage

`default_nettype wire

@@ src/pgd_in_if.sv @@
// ---------------------------------------------------------------------------
// pgd_in_if: input channel carrying one pair of uniform words
// Valid/ready channel; a beat moves when both are high at a clock edge.
// ---------------------------------------------------------------------------
`default_nettype none

interface pgd_in_if;
  logic        valid;
  logic        ready;
  logic [30:0] uniform_first;
  logic [30:0] uniform_second;

  modport source (output valid, output uniform_first, output uniform_second,
                  input ready);
  modport sink   (input valid, input uniform_first, input uniform_second,
                  output ready);
endinterface

`default_nettype wire

@@ src/pgd_out_if.sv @@
// ---------------------------------------------------------------------------
// pgd_out_if: output channel carrying one normal deviate per beat
// Valid/ready channel; last marks the second deviate of a pair.
// ---------------------------------------------------------------------------
`default_nettype none

interface pgd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] deviate;
  logic               last;

  modport source (output valid, output deviate, output last, input ready);
  modport sink   (input valid, input deviate, input last, output ready);
endinterface

`default_nettype wire

@@ src/pgd_front.sv @@
// ---------------------------------------------------------------------------
// pgd_front: input mapping, squared radius and rejection
// Two-stage pipeline that maps uniform words to odd signed coordinates,
// squares them, drops pairs outside the unit circle and queues the rest.
// ---------------------------------------------------------------------------
`default_nettype none

module pgd_front (
  input  logic                clk,
  input  logic                rst_n,
  pgd_in_if.sink              in_bus,
  input  logic                fifo_full,
  output logic                push,
  output pgd_pkg::pgd_entry_t push_data
);

  logic        v1_r, v2_r;
  logic [30:0] mag_a_r, mag_b_r;
  logic        neg_a1_r, neg_b1_r;
  logic [61:0] sq_a_r, sq_b_r;
  logic        neg_a2_r, neg_b2_r;
  logic [30:0] mag_a, mag_b;
  logic        neg_a, neg_b;
  logic [62:0] s_sum;
  logic        keep;
  logic        en;

  // Magnitude and sign of 2u - (2^31 - 1); bit 30 is the top input bit.
  function automatic logic [31:0] map_word(input logic [30:0] u);
    logic [31:0] twice;
    twice = {u, 1'b0};
    if (twice >= pgd_pkg::HALF_RANGE) begin
      map_word = {1'b0, 31'(twice - pgd_pkg::HALF_RANGE)};
    end else begin
      map_word = {1'b1, 31'(pgd_pkg::HALF_RANGE - twice)};
    end
  endfunction

  always_comb begin
    {neg_a, mag_a} = map_word(in_bus.uniform_first);
    {neg_b, mag_b} = map_word(in_bus.uniform_second);
  end

  // The squared radius is exact; zero or at least one (2^62) is rejected.
  assign s_sum = {1'b0, sq_a_r} + {1'b0, sq_b_r};
  assign keep  = (s_sum != 63'd0) && !s_sum[62];

  // The pipeline moves unless a kept pair waits on a full queue.
  assign en            = !v2_r || !keep || !fifo_full;
  assign in_bus.ready  = en;
  assign push          = v2_r && keep && !fifo_full;

  always_comb begin
    push_data.sq_a  = sq_a_r;
    push_data.sq_b  = sq_b_r;
    push_data.s_int = s_sum[61:0];
    push_data.neg_a = neg_a2_r;
    push_data.neg_b = neg_b2_r;
  end

  // Stage registers: mapped coordinates, then their squares.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r     <= in_bus.valid;
      mag_a_r  <= mag_a;
      mag_b_r  <= mag_b;
      neg_a1_r <= neg_a;
      neg_b1_r <= neg_b;
      v2_r     <= v1_r;
      sq_a_r   <= {31'd0, mag_a_r} * {31'd0, mag_a_r};
      sq_b_r   <= {31'd0, mag_b_r} * {31'd0, mag_b_r};
      neg_a2_r <= neg_a1_r;
      neg_b2_r <= neg_b1_r;
    end
  end

endmodule

`default_nettype wire

@@ src/pgd_fifo.sv @@
// ---------------------------------------------------------------------------
// pgd_fifo: short queue between the front and the back
// Register-based first-in first-out store of accepted pairs.
// ---------------------------------------------------------------------------
`default_nettype none

module pgd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pgd_pkg::pgd_entry_t push_data,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output pgd_pkg::pgd_entry_t pop_data
);

  localparam int CNT_W = pgd_pkg::FIFO_PTR_W + 1;

  pgd_pkg::pgd_entry_t          mem_r [pgd_pkg::FIFO_DEPTH];
  logic [pgd_pkg::FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]              cnt_r;
  logic                          do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(pgd_pkg::FIFO_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ src/pgd_back.sv @@
// ---------------------------------------------------------------------------
// pgd_back: sequencer that turns one queued pair into two deviates
// Shared bit-serial divider, multiplier and square root units compute
// -ln s, the radial scale and both deviates, then fill the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module pgd_back #(
  parameter int OUT_FRAC_BITS = pgd_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fifo_empty,
  input  pgd_pkg::pgd_entry_t pop_data,
  output logic                pop,
  pgd_out_if.source           out_bus
);

  localparam int          SHIFT    = 59 - OUT_FRAC_BITS;
  localparam logic [5:0]  LAST62   = 6'd61;
  localparam logic [5:0]  LAST32   = 6'd31;
  localparam logic [63:0] BIT_TOP  = 64'h4000_0000_0000_0000;
  localparam logic [62:0] ONE_Q61  = 63'h2000_0000_0000_0000;
  localparam logic [63:0] HALF_RND = 64'd1 << (SHIFT - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_NORM, ST_FDIV, ST_MULY, ST_SCHK, ST_SERIES,
    ST_LOGF, ST_ISQRT, ST_DEVST, ST_MULC, ST_EMIT
  } state_t;

  state_t              state_r;
  pgd_pkg::pgd_entry_t ent_r;
  logic [61:0] x_r;
  logic [5:0]  shc_r;
  logic [5:0]  cnt_r;
  logic        phase_r;
  logic        sel_r;
  logic [62:0] fd_rem_r, fd_den_r;
  logic [61:0] fd_q_r;
  logic [61:0] mul_x_r, mul_y_r, acc_r;
  logic [61:0] y2_r, term_r;
  logic [7:0]  k_r;
  logic [61:0] dv_src_r, dv_q_r;
  logic [7:0]  dv_rem_r;
  logic [63:0] sum_r;
  logic [63:0] sq_x_r, sq_r_r, sq_bit_r;
  logic [31:0] t_r;
  logic [30:0] c_r;
  logic [63:0] prod_r;
  logic        ov_r;
  logic [31:0] dev_r;
  logic        last_r;

  logic [63:0] fd_shift;
  logic        fd_ge;
  logic [62:0] fd_rem_step;
  logic [61:0] fd_q_step;
  logic [62:0] mul_sum;
  logic [61:0] acc_step;
  logic [8:0]  dv_cat;
  logic        dv_ge;
  logic [7:0]  dv_rem_step;
  logic [61:0] dv_q_step;
  logic [63:0] sq_trial, sq_x_step, sq_r_step;
  logic        sq_ge;
  logic [63:0] lnx, whole, l_q56;
  logic [63:0] rnd, mag64;
  logic [31:0] mag32, dev;
  logic        out_free;
  logic        emit_go;

  // Restoring fractional divider, one quotient bit per cycle.
  always_comb begin
    fd_shift    = {fd_rem_r, 1'b0};
    fd_ge       = fd_shift >= {1'b0, fd_den_r};
    fd_rem_step = fd_ge ? 63'(fd_shift - {1'b0, fd_den_r}) : fd_shift[62:0];
    fd_q_step   = {fd_q_r[60:0], fd_ge};
  end

  // Shift-add multiplier that keeps the product scaled by 2^-62.
  always_comb begin
    mul_sum  = {1'b0, acc_r} + (mul_y_r[0] ? {1'b0, mul_x_r} : 63'd0);
    acc_step = mul_sum[62:1];
  end

  // Long division of a series term by its small odd index.
  always_comb begin
    dv_cat      = {dv_rem_r, dv_src_r[61]};
    dv_ge       = dv_cat >= {1'b0, k_r};
    dv_rem_step = dv_ge ? 8'(dv_cat - {1'b0, k_r}) : dv_cat[7:0];
    dv_q_step   = {dv_q_r[60:0], dv_ge};
  end

  // Digit-by-digit integer square root, one result bit per cycle.
  always_comb begin
    sq_trial  = sq_r_r + sq_bit_r;
    sq_ge     = sq_x_r >= sq_trial;
    sq_x_step = sq_ge ? (sq_x_r - sq_trial) : sq_x_r;
    sq_r_step = sq_ge ? ((sq_r_r >> 1) + sq_bit_r) : (sq_r_r >> 1);
  end

  // -ln s = (62 - p) ln 2 - ln x, with ln x rounded to 56 fraction bits.
  always_comb begin
    lnx   = ({sum_r[62:0], 1'b0} + 64'd32) >> 6;
    whole = pgd_pkg::LN2_Q56 * 64'({1'b0, shc_r} + 7'd1);
    l_q56 = (whole > lnx) ? (whole - lnx) : 64'd0;
  end

  // Rounding to the output format, saturation and sign.
  always_comb begin
    rnd   = prod_r + HALF_RND;
    mag64 = rnd >> SHIFT;
    mag32 = (mag64 > {32'd0, pgd_pkg::HALF_RANGE}) ? pgd_pkg::HALF_RANGE : mag64[31:0];
    dev   = (sel_r ? ent_r.neg_b : ent_r.neg_a) ? (32'd0 - mag32) : mag32;
  end

  assign out_free        = !ov_r || out_bus.ready;
  assign emit_go         = (state_r == ST_EMIT) && out_free;
  assign pop             = (state_r == ST_IDLE) && !fifo_empty;
  assign out_bus.valid   = ov_r;
  assign out_bus.deviate = dev_r;
  assign out_bus.last    = last_r;

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      if (emit_go) begin
        ov_r <= 1'b1;
      end else if (ov_r && out_bus.ready) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!fifo_empty) begin
            ent_r   <= pop_data;
            x_r     <= pop_data.s_int;
            shc_r   <= 6'd0;
            state_r <= ST_NORM;
          end
        end
        // Normalize s to [1, 2) one position a cycle.
        ST_NORM: begin
          if (x_r[61]) begin
            fd_rem_r <= {2'b00, x_r[60:0]};
            fd_den_r <= {1'b0, x_r} + ONE_Q61;
            fd_q_r   <= 62'd0;
            cnt_r    <= 6'd0;
            phase_r  <= 1'b0;
            state_r  <= ST_FDIV;
          end else begin
            x_r   <= {x_r[60:0], 1'b0};
            shc_r <= shc_r + 6'd1;
          end
        end
        ST_FDIV: begin
          fd_rem_r <= fd_rem_step;
          fd_q_r   <= fd_q_step;
          if (cnt_r == LAST62) begin
            cnt_r <= 6'd0;
            if (!phase_r) begin
              term_r  <= fd_q_step;
              mul_x_r <= fd_q_step;
              mul_y_r <= fd_q_step;
              acc_r   <= 62'd0;
              state_r <= ST_MULY;
            end else begin
              sq_x_r   <= {2'b00, fd_q_step};
              sq_r_r   <= 64'd0;
              sq_bit_r <= BIT_TOP;
              state_r  <= ST_ISQRT;
            end
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        ST_MULY: begin
          acc_r   <= acc_step;
          mul_y_r <= mul_y_r >> 1;
          cnt_r   <= cnt_r + 6'd1;
          if (cnt_r == LAST62) begin
            y2_r    <= acc_step;
            sum_r   <= 64'd0;
            k_r     <= 8'd1;
            state_r <= ST_SCHK;
          end
        end
        // Next odd term of the arctanh series, until it vanishes or the index reaches its limit.
        ST_SCHK: begin
          if ((term_r != 62'd0) && (k_r < pgd_pkg::SERIES_K_LIMIT)) begin
            mul_x_r  <= term_r;
            mul_y_r  <= y2_r;
            acc_r    <= 62'd0;
            dv_src_r <= term_r;
            dv_rem_r <= 8'd0;
            dv_q_r   <= 62'd0;
            cnt_r    <= 6'd0;
            state_r  <= ST_SERIES;
          end else begin
            state_r <= ST_LOGF;
          end
        end
        ST_SERIES: begin
          acc_r    <= acc_step;
          mul_y_r  <= mul_y_r >> 1;
          dv_src_r <= {dv_src_r[60:0], 1'b0};
          dv_rem_r <= dv_rem_step;
          dv_q_r   <= dv_q_step;
          cnt_r    <= cnt_r + 6'd1;
          if (cnt_r == LAST62) begin
            sum_r   <= sum_r + {2'b00, dv_q_step};
            term_r  <= acc_step;
            k_r     <= k_r + 8'd2;
            state_r <= ST_SCHK;
          end
        end
        ST_LOGF: begin
          sq_x_r   <= {l_q56[62:0], 1'b0};
          sq_r_r   <= 64'd0;
          sq_bit_r <= BIT_TOP;
          cnt_r    <= 6'd0;
          state_r  <= ST_ISQRT;
        end
        ST_ISQRT: begin
          sq_x_r   <= sq_x_step;
          sq_r_r   <= sq_r_step;
          sq_bit_r <= sq_bit_r >> 2;
          cnt_r    <= cnt_r + 6'd1;
          if (cnt_r == LAST32) begin
            if (!phase_r) begin
              t_r     <= sq_r_step[31:0];
              sel_r   <= 1'b0;
              state_r <= ST_DEVST;
            end else begin
              c_r     <= sq_r_step[30:0];
              state_r <= ST_MULC;
            end
          end
        end
        // Coordinate squared over s, for the selected deviate.
        ST_DEVST: begin
          fd_rem_r <= {1'b0, sel_r ? ent_r.sq_b : ent_r.sq_a};
          fd_den_r <= {1'b0, ent_r.s_int};
          fd_q_r   <= 62'd0;
          cnt_r    <= 6'd0;
          phase_r  <= 1'b1;
          state_r  <= ST_FDIV;
        end
        ST_MULC: begin
          prod_r  <= {33'd0, c_r} * {32'd0, t_r};
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            dev_r  <= dev;
            last_r <= sel_r;
            if (sel_r) begin
              state_r <= ST_IDLE;
            end else begin
              sel_r   <= 1'b1;
              state_r <= ST_DEVST;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/polar_gaussian_deviate_pair_core.sv @@
// ---------------------------------------------------------------------------
// polar_gaussian_deviate_pair_core: polar-method normal deviate generator
// Maps uniform pairs into the unit square, rejects those outside the unit
// circle and emits two scaled normal deviates for each pair kept.
// ---------------------------------------------------------------------------
//  Channel   Dir  Handshake     Beat contents
//  in_bus    in   valid/ready   uniform_first, uniform_second (31 bits each)
//  out_bus   out  valid/ready   deviate (signed 32 bits), last
//
// The front takes one pair per cycle into a two-stage pipeline, unless a
// kept pair waits on a full queue; rejected pairs vanish there and kept
// pairs enter a four-entry queue. The back works on one pair at a time,
// through the normalize steps, the bit-serial divider and multiplier that
// sum the logarithm series, and the division and square root per deviate.
// Reset is synchronous and active low; it empties the pipeline and queue.
// A stalled output holds its beat while the front keeps filling the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module polar_gaussian_deviate_pair_core #(
  parameter int OUT_FRAC_BITS = pgd_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pgd_in_if.sink    in_bus,
  pgd_out_if.source out_bus
);

  logic                fifo_full, fifo_empty;
  logic                push, pop;
  pgd_pkg::pgd_entry_t push_data, pop_data;

  pgd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .fifo_full (fifo_full),
    .push      (push),
    .push_data (push_data)
  );

  pgd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (fifo_full),
    .empty     (fifo_empty),
    .pop_data  (pop_data)
  );

  pgd_back #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_bus    (out_bus)
  );

  // The front only stalls when a kept pair finds the queue full.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> fifo_full)
    else $error("front stalled while the queue had room");

  // The queue is never both full and empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(fifo_full && fifo_empty))
    else $error("queue fill count inconsistent");

  // A push without a pop leaves the queue holding something.
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> !fifo_empty)
    else $error("queued pair lost");

endmodule

`default_nettype wire

@@ dv/polar_gaussian_deviate_pair_core_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// polar_gaussian_deviate_pair_core_tb: self-checking bench for the core
// Drives uniform pairs with random gaps and a randomly stalling receiver.
// A scoreboard predicts both deviates of every kept pair in exact integer
// arithmetic and checks each output beat in order.
// ---------------------------------------------------------------------------
`default_nettype none

module polar_gaussian_deviate_pair_core_tb;

  localparam int FRAC_BITS = pgd_pkg::OUT_FRAC_BITS_DEF;
  localparam int RANDOM_PAIRS = 1330;

  typedef struct {
    logic signed [31:0] deviate;
    logic               last;
  } deviate_beat_t;

  // Predicts the deviates of each accepted pair and checks the outputs.
  class deviate_scoreboard;
    deviate_beat_t pending_q[$];
    int            mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Product of two Q62 values, shifted right by 62 bits (bits 125 to 62).
    function bit [63:0] mul_q62(bit [63:0] x, bit [63:0] y);
      bit [127:0] p;
      p = x * y;
      return p[125:62];
    endfunction

    // floor(num * 2^bits / den) for num < den.
    function bit [63:0] frac_div(bit [63:0] num, bit [63:0] den, int bits);
      bit [63:0] q;
      bit [63:0] r;
      q = 0;
      r = num;
      for (int i = 0; i < bits; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q[0] = 1'b1;
        end
      end
      return q;
    endfunction

    function bit [63:0] int_sqrt(bit [63:0] x);
      bit [63:0] r;
      bit [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // -ln(S * 2^-62) with 56 fraction bits.
    function bit [63:0] neg_log_q56(bit [63:0] s_int);
      int        p;
      bit [63:0] x;
      bit [63:0] y;
      bit [63:0] y2;
      bit [63:0] term;
      bit [63:0] sum;
      bit [63:0] lnx;
      bit [63:0] whole;
      p = 0;
      while (p < 63 && (s_int >> (p + 1)) != 0) p++;
      x = s_int << (61 - p);
      y = frac_div(x - (64'd1 << 61), x + (64'd1 << 61), 62);
      y2 = mul_q62(y, y);
      term = y;
      sum = 0;
      for (int k = 1; k < 200 && term != 0; k += 2) begin
        sum = sum + term / k;
        term = mul_q62(term, y2);
      end
      lnx = ((sum << 1) + 64'd32) >> 6;
      whole = 64'(62 - p) * pgd_pkg::LN2_Q56;
      return (whole > lnx) ? whole - lnx : 64'd0;
    endfunction

    // Centered odd magnitude of a uniform word, with its sign.
    function bit [63:0] centered_mag(bit [30:0] u, output bit neg);
      bit [63:0] twice;
      twice = {32'd0, u, 1'b0};
      if (twice >= 64'h7FFF_FFFF) begin
        neg = 1'b0;
        return twice - 64'h7FFF_FFFF;
      end
      neg = 1'b1;
      return 64'h7FFF_FFFF - twice;
    endfunction

    function logic [31:0] scaled_deviate(bit [63:0] mag, bit neg, bit [63:0] s_int,
                                         bit [63:0] t28);
      bit [63:0] c31;
      bit [63:0] r;
      c31 = int_sqrt(frac_div(mag * mag, s_int, 62));
      r = (c31 * t28 + (64'd1 << (58 - FRAC_BITS))) >> (59 - FRAC_BITS);
      if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
      return neg ? -r[31:0] : r[31:0];
    endfunction

    // Notes one accepted pair; kept pairs queue two expected deviates.
    function void note_pair(bit [30:0] u1, bit [30:0] u2);
      bit            na;
      bit            nb;
      bit [63:0]     a;
      bit [63:0]     b;
      bit [63:0]     s_int;
      bit [63:0]     t28;
      deviate_beat_t beat;
      a = centered_mag(u1, na);
      b = centered_mag(u2, nb);
      s_int = a * a + b * b;
      if (s_int == 0 || s_int >= (64'd1 << 62)) return;
      t28 = int_sqrt(neg_log_q56(s_int) << 1);
      beat.deviate = scaled_deviate(a, na, s_int, t28);
      beat.last = 1'b0;
      pending_q.push_back(beat);
      beat.deviate = scaled_deviate(b, nb, s_int, t28);
      beat.last = 1'b1;
      pending_q.push_back(beat);
    endfunction

    function void check_beat(logic signed [31:0] deviate, logic last);
      deviate_beat_t exp_beat;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected beat deviate=%h last=%b", $time, deviate, last);
        mismatches++;
        return;
      end
      exp_beat = pending_q.pop_front();
      if (deviate !== exp_beat.deviate) begin
        $display("%0t: deviate mismatch expected %h actual %h", $time,
                 exp_beat.deviate, deviate);
        mismatches++;
      end
      if (last !== exp_beat.last) begin
        $display("%0t: last mismatch expected %b actual %b", $time,
                 exp_beat.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  pgd_in_if  in_bus ();
  pgd_out_if out_bus ();

  deviate_scoreboard sb = new();

  polar_gaussian_deviate_pair_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus.sink),
    .out_bus(out_bus.source)
  );

  // Clock: 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Input and output beat monitors.
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready)
      sb.note_pair(in_bus.uniform_first, in_bus.uniform_second);
    if (rst_n && out_bus.valid && out_bus.ready)
      sb.check_beat(out_bus.deviate, out_bus.last);
  end

  function int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Offers one pair, after an optional idle gap, and waits until it is accepted.
  task automatic send_pair(bit [30:0] u1, bit [30:0] u2, bit use_gap);
    int gap;
    gap = use_gap ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_bus.valid <= 1'b1;
    in_bus.uniform_first <= u1;
    in_bus.uniform_second <= u2;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Random word: full range, near the center, or near the square's edge.
  function bit [30:0] pick_word();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return 31'($urandom);
    if (roll < 85)
      return 31'(32'h4000_0000 + $urandom_range(2048) - 1024) ^
             31'($urandom_range(1) ? 0 : ($urandom & 32'h0000_FFFF));
    return $urandom_range(1) ? 31'($urandom_range(31'h7FFF_FFFF, 31'h7FF0_0000))
                             : 31'($urandom_range(32'h000F_FFFF));
  endfunction

  // Receiver: one long hold-off after reset, then random stalls.
  initial begin
    int stall;
    int roll;
    out_bus.ready = 1'b0;
    stall = 0;
    wait (rst_n === 1'b1);
    repeat (4000) @(negedge clk);
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        out_bus.ready <= 1'b0;
      end else begin
        roll = $urandom_range(99);
        if (roll < 85) begin
          out_bus.ready <= 1'b1;
        end else begin
          out_bus.ready <= 1'b0;
          stall = (roll < 97) ? $urandom_range(3) : $urandom_range(300, 50);
        end
      end
    end
  end

  // Reset, directed pairs, random pairs, then drain and report.
  initial begin
    in_bus.valid = 1'b0;
    in_bus.uniform_first = '0;
    in_bus.uniform_second = '0;
    rst_n = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Corners of the square lie outside the circle.
    send_pair(31'h0000_0000, 31'h0000_0000, 1'b0);
    send_pair(31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
    send_pair(31'h0000_0000, 31'h7FFF_FFFF, 1'b0);
    // Smallest radius, every sign combination.
    send_pair(31'h3FFF_FFFF, 31'h4000_0000, 1'b0);
    send_pair(31'h4000_0000, 31'h3FFF_FFFF, 1'b0);
    send_pair(31'h3FFF_FFFF, 31'h3FFF_FFFF, 1'b0);
    send_pair(31'h4000_0000, 31'h4000_0000, 1'b0);
    // Just inside the circle on each axis.
    send_pair(31'h7FFF_FFFF, 31'h4000_0000, 1'b0);
    send_pair(31'h0000_0000, 31'h3FFF_FFFF, 1'b0);
    send_pair(31'h4000_0000, 31'h7FFF_FFFF, 1'b0);
    send_pair(31'h3FFF_FFFF, 31'h0000_0000, 1'b0);
    // Still just inside the circle, one step off the axis.
    send_pair(31'h7FFF_FFFF, 31'h4000_0001, 1'b0);
    // Mid-range points on the diagonals.
    send_pair(31'h6000_0000, 31'h6000_0000, 1'b1);
    send_pair(31'h2000_0000, 31'h6000_0000, 1'b1);
    send_pair(31'h2AAA_AAAA, 31'h5555_5555, 1'b1);
    send_pair(31'h5555_5555, 31'h2AAA_AAAA, 1'b1);

    for (int i = 0; i < RANDOM_PAIRS; i++)
      send_pair(pick_word(), pick_word(), 1'b1);
    @(negedge clk);
    in_bus.valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("polar_gaussian_deviate_pair_core verification clean");
    else
      $display("polar_gaussian_deviate_pair_core verification failed");
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #600_000_000;
    $display("polar_gaussian_deviate_pair_core verification failed");
    $finish;
  end

endmodule

`default_nettype wire
